[design/src_pkg.sv]
// Shared types and constants for the signal region caller.
package src_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_READ_WEAK    = 3'd0;
  localparam logic [2:0] REG_READ_STRONG  = 3'd1;
  localparam logic [2:0] REG_MULTI_WEAK   = 3'd2;
  localparam logic [2:0] REG_MULTI_STRONG = 3'd3;
  localparam logic [2:0] REG_READ_FLOOR   = 3'd4;
  localparam logic [2:0] REG_WIN_LENGTH   = 3'd5;
  localparam logic [2:0] REG_WIN_STEP     = 3'd6;
  localparam logic [2:0] REG_GAP_LIMIT    = 3'd7;

  localparam logic [15:0] WIN_LENGTH_RST = 16'd1000;
  localparam logic [15:0] WIN_STEP_RST   = 16'd100;
  localparam logic [7:0]  GAP_LIMIT_RST  = 8'd15;

  localparam logic [23:0] TALLY_MAX = 24'hFF_FFFF;

  // Queue depths as address widths
  localparam int MID_AW = 2;
  localparam int OUT_AW = 2;

  typedef struct packed {
    logic [31:0] read_level;
    logic [31:0] multi_level;
    logic        final_bin;
  } src_in_t;

  typedef struct packed {
    logic [39:0] region_start;
    logic [40:0] region_end;
    logic [1:0]  hit_kind;
    logic [23:0] hit_total;
  } src_out_t;

  typedef struct packed {
    logic [31:0] read_weak_level;
    logic [31:0] read_strong_level;
    logic [31:0] multi_weak_level;
    logic [31:0] multi_strong_level;
    logic [31:0] read_floor_level;
    logic [15:0] window_length;
    logic [15:0] window_step;
    logic [7:0]  gap_limit;
  } src_cfg_t;

  // Classified bin handed from front to back
  typedef struct packed {
    logic flag;
    logic read_hit;
    logic multi_hit;
    logic final_bin;
  } src_cls_t;

endpackage

[design/signal_region_caller.sv]
// Top level of the signal region caller: config registers, front, queues, back.
//
// Usage: bins enter on the in_ queue port (in_push / in_full), one per cycle
// at full rate while in_full stays low. A bin transfers on a rising edge with
// in_push high and in_full low. Results leave on the out_ queue port: out_item
// holds the oldest result while out_empty is low, and it transfers on an edge
// with out_pop high. At most one result per bin; a result appears only when a
// region with a strong hit closes or is flushed by a final bin.
// Path: the front register loads on the edge on which a bin transfers; a result
// it causes then passes through the classified-bin queue, region event register,
// product stage and result queue. Throughput: one bin per cycle unless the back
// end holds off; the tracker update, a loop on its own state, sets this rate.
// When the receiver stalls, results collect in a 4-entry queue; the back end
// holds off draining the middle queue once every result slot is reserved, and
// in_full rises when the middle queue and the front register are full.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// Reset (rst_n low, synchronous) empties all queues, clears the region state
// and bin counter, and loads the register defaults.
module signal_region_caller #(
  parameter int BIN_INDEX_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  src_pkg::src_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output src_pkg::src_out_t out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import src_pkg::*;

  src_cfg_t cfg_r, cfg_nxt;

  logic              mid_push, mid_pop, mid_empty, mid_full;
  logic [MID_AW:0]   mid_count;
  src_cls_t          mid_wdata, mid_rdata;

  logic              out_wr, out_q_full;
  logic [OUT_AW:0]   out_count;
  src_out_t          out_wdata;

  // Register writes: decode index, drop nothing else
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_READ_WEAK:    cfg_nxt.read_weak_level    = cfg_wdata;
        REG_READ_STRONG:  cfg_nxt.read_strong_level  = cfg_wdata;
        REG_MULTI_WEAK:   cfg_nxt.multi_weak_level   = cfg_wdata;
        REG_MULTI_STRONG: cfg_nxt.multi_strong_level = cfg_wdata;
        REG_READ_FLOOR:   cfg_nxt.read_floor_level   = cfg_wdata;
        REG_WIN_LENGTH:   cfg_nxt.window_length      = cfg_wdata[15:0];
        REG_WIN_STEP:     cfg_nxt.window_step        = cfg_wdata[15:0];
        REG_GAP_LIMIT:    cfg_nxt.gap_limit          = cfg_wdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_weak_level    <= '0;
      cfg_r.read_strong_level  <= '0;
      cfg_r.multi_weak_level   <= '0;
      cfg_r.multi_strong_level <= '0;
      cfg_r.read_floor_level   <= '0;
      cfg_r.window_length      <= WIN_LENGTH_RST;
      cfg_r.window_step        <= WIN_STEP_RST;
      cfg_r.gap_limit          <= GAP_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify incoming bins
  src_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_wdata)
  );

  // Decouple classification from region tracking
  src_fifo #(.W($bits(src_cls_t)), .AW(MID_AW)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mid_push),
    .wdata (mid_wdata),
    .rd    (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  // Track regions and build results
  src_back #(.BIN_INDEX_BITS(BIN_INDEX_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_item  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_wr    (out_wr),
    .out_data  (out_wdata)
  );

  // Hold results until the receiver takes them
  src_fifo #(.W($bits(src_out_t)), .AW(OUT_AW)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (out_wr),
    .wdata (out_wdata),
    .rd    (out_pop),
    .rdata (out_item),
    .empty (out_empty),
    .full  (out_q_full),
    .count (out_count)
  );

`ifndef SYNTHESIS
  // Slot reservation must keep the result queue from overflowing
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> !out_q_full)
    else $error("result written into full queue");

  // Front must never push into a full middle queue
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> !mid_full)
    else $error("classified bin pushed into full queue");

  // Every reported region holds at least one strong hit
  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.hit_kind != 2'b00) && (out_item.hit_total != 24'd0))
    else $error("result without a strong hit");

  // Middle queue count never exceeds its depth
  a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
    mid_count <= (MID_AW+1)'(1 << MID_AW))
    else $error("middle queue count out of range");
`endif

endmodule

[design/src_fifo.sv]
// Small register-based FIFO used between stages and at the result side.
module src_fifo #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  logic [W-1:0]  wdata,
  input  logic          rd,
  output logic [W-1:0]  rdata,
  output logic          empty,
  output logic          full,
  output logic [AW:0]   count
);
  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign rdata = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + AW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[design/src_front.sv]
// Front stage: accept bins and classify them against the thresholds.
module src_front (
  input  logic               clk,
  input  logic               rst_n,
  input  src_pkg::src_cfg_t  cfg,
  input  logic               in_push,
  input  src_pkg::src_in_t   in_item,
  output logic               in_full,
  input  logic               mid_full,
  output logic               mid_push,
  output src_pkg::src_cls_t  mid_item
);
  import src_pkg::*;

  logic     valid_r, valid_nxt;
  src_cls_t cls_r, cls_nxt;
  logic     advance, accept;

  assign in_full  = valid_r && mid_full;
  assign accept   = in_push && !in_full;
  assign advance  = !valid_r || !mid_full;
  assign mid_push = valid_r && !mid_full;
  assign mid_item = cls_r;

  always_comb begin
    cls_nxt.flag = (in_item.read_level >= cfg.read_weak_level) ||
                   (in_item.multi_level >= cfg.multi_weak_level) ||
                   (in_item.read_level <= cfg.read_floor_level);
    // Hits only count inside a flagged bin
    cls_nxt.read_hit  = cls_nxt.flag && (in_item.read_level >= cfg.read_strong_level);
    cls_nxt.multi_hit = cls_nxt.flag && (in_item.multi_level > cfg.multi_strong_level);
    cls_nxt.final_bin = in_item.final_bin;
    valid_nxt = advance ? accept : valid_r;
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      cls_r <= cls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end
endmodule

[design/src_back.sv]
// Back stage: region tracking, coordinate products and result write.
module src_back #(
  parameter int BIN_INDEX_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  src_pkg::src_cfg_t   cfg,
  input  logic                mid_empty,
  input  src_pkg::src_cls_t   mid_item,
  output logic                mid_pop,
  input  logic [src_pkg::OUT_AW:0] out_count,
  output logic                out_wr,
  output src_pkg::src_out_t   out_data
);
  import src_pkg::*;

  localparam int BW = BIN_INDEX_BITS;
  localparam int PW = BIN_INDEX_BITS + 16;
  localparam int OUT_DEPTH = 1 << OUT_AW;

  // Tracker state
  logic [BW-1:0] bin_r, bin_nxt;
  logic          open_r, open_nxt;
  logic [7:0]    miss_r, miss_nxt;
  logic [BW-1:0] first_r, first_nxt;
  logic [BW-1:0] last_r, last_nxt;
  logic [1:0]    bits_r, bits_nxt;
  logic [23:0]   tally_r, tally_nxt;

  // Region event stage
  logic          ev_v_r, ev_v_nxt;
  logic [BW-1:0] ev_first_r, ev_last_r;
  logic [1:0]    ev_bits_r;
  logic [23:0]   ev_tally_r;

  // Product stage
  logic          pr_v_r;
  logic [PW-1:0] pr_start_r, pr_end_r;
  logic [1:0]    pr_bits_r;
  logic [23:0]   pr_tally_r;

  logic [OUT_AW+1:0] pending;
  logic [BW-1:0]     first_u, last_u;
  logic [1:0]        bits_u;
  logic [23:0]       tally_u;
  logic [24:0]       tsum;
  logic              close;

  // Reserve a result slot for every item in flight
  assign pending = (OUT_AW+2)'(out_count) + (OUT_AW+2)'(ev_v_r) + (OUT_AW+2)'(pr_v_r);
  assign mid_pop = !mid_empty && (pending < (OUT_AW+2)'(OUT_DEPTH));

  always_comb begin
    tsum = {1'b0, tally_r} + 25'(mid_item.read_hit) + 25'(mid_item.multi_hit);
    first_u = first_r;
    last_u  = last_r;
    bits_u  = bits_r;
    tally_u = tally_r;
    if (mid_item.flag) begin
      last_u  = bin_r;
      first_u = open_r ? first_r : bin_r;
      bits_u  = bits_r | {mid_item.multi_hit, mid_item.read_hit};
      tally_u = tsum[24] ? TALLY_MAX : tsum[23:0];
    end
    close = !mid_item.flag && (miss_r >= cfg.gap_limit);

    bin_nxt   = bin_r;
    open_nxt  = open_r;
    miss_nxt  = miss_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    bits_nxt  = bits_r;
    tally_nxt = tally_r;
    ev_v_nxt  = 1'b0;

    if (mid_pop) begin
      first_nxt = first_u;
      last_nxt  = last_u;
      bits_nxt  = bits_u;
      tally_nxt = tally_u;
      if (mid_item.flag) begin
        miss_nxt = '0;
        open_nxt = 1'b1;
      end else if (!close) begin
        miss_nxt = miss_r + 8'd1;
      end else begin
        open_nxt  = 1'b0;
        bits_nxt  = '0;
        tally_nxt = '0;
      end
      // Emit on a close or a flush while the region holds a hit
      ev_v_nxt = (close || mid_item.final_bin) && (bits_u != 2'b00);
      if (mid_item.final_bin) begin
        bin_nxt   = '0;
        open_nxt  = 1'b0;
        miss_nxt  = '0;
        first_nxt = '0;
        last_nxt  = '0;
        bits_nxt  = '0;
        tally_nxt = '0;
      end else begin
        bin_nxt = bin_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_v_nxt) begin
      ev_first_r <= first_u;
      ev_last_r  <= last_u;
      ev_bits_r  <= bits_u;
      ev_tally_r <= tally_u;
    end
    if (ev_v_r) begin
      pr_start_r <= PW'(ev_first_r) * PW'(cfg.window_step);
      pr_end_r   <= PW'(ev_last_r) * PW'(cfg.window_step);
      pr_bits_r  <= ev_bits_r;
      pr_tally_r <= ev_tally_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r   <= '0;
      open_r  <= 1'b0;
      miss_r  <= '0;
      first_r <= '0;
      last_r  <= '0;
      bits_r  <= '0;
      tally_r <= '0;
      ev_v_r  <= 1'b0;
      pr_v_r  <= 1'b0;
    end else begin
      bin_r   <= bin_nxt;
      open_r  <= open_nxt;
      miss_r  <= miss_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      bits_r  <= bits_nxt;
      tally_r <= tally_nxt;
      ev_v_r  <= ev_v_nxt;
      pr_v_r  <= ev_v_r;
    end
  end

  assign out_wr = pr_v_r;
  always_comb begin
    out_data.region_start = 40'(pr_start_r);
    out_data.region_end   = 41'(pr_end_r) + 41'(cfg.window_length);
    out_data.hit_kind     = pr_bits_r;
    out_data.hit_total    = pr_tally_r;
  end
endmodule

[tb/signal_region_caller_tb.sv]
// Self-checking testbench for the signal region caller: bin stream in, called regions out.
`timescale 1ns / 1ps

module signal_region_caller_tb;
  import src_pkg::*;

  // Run length guard and timing figures
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;     // drain margin past the block's pipeline
  localparam int RX_HOLD       = 400;    // long receiver hold-off, in cycles
  localparam longint U32_MAX   = 64'h0000_0000_FFFF_FFFF;

  // Shapes of bins relative to the current thresholds
  typedef enum int {
    BK_QUIET,
    BK_PLAIN,
    BK_RHIT,
    BK_MHIT,
    BK_BOTH,
    BK_NOISE
  } bin_kind_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  src_in_t    in_item = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  src_out_t   out_item;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Bins waiting to be offered, and called regions waiting to come out
  src_in_t  bin_q[$];
  src_out_t pending_regions[$];

  // Register copy for prediction; starts at the reset values
  src_cfg_t cfg_model = '{read_weak_level: '0, read_strong_level: '0,
                          multi_weak_level: '0, multi_strong_level: '0,
                          read_floor_level: '0, window_length: WIN_LENGTH_RST,
                          window_step: WIN_STEP_RST, gap_limit: GAP_LIMIT_RST};

  // Region tracker state of the predictor
  logic [23:0] bin_idx   = '0;
  logic        reg_open  = 1'b0;
  logic [7:0]  miss_cnt  = '0;
  logic [23:0] reg_first = '0;
  logic [23:0] reg_last  = '0;
  logic        hit_flag  = 1'b0;
  logic [1:0]  hit_code  = '0;
  logic [23:0] hit_cnt   = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  logic rx_hold_req = 1'b0;
  int fed = 0;
  int err_count = 0;
  int cycle_count = 0;

  signal_region_caller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: called region for the tracker state as it stands now
  // ---------------------------------------------------------------------------
  function automatic src_out_t region_report();
    src_out_t r;
    logic [40:0] span;
    r.region_start = 40'(reg_first) * 40'(cfg_model.window_step);
    span = 41'(reg_last) * 41'(cfg_model.window_step);
    r.region_end = span + 41'(cfg_model.window_length);
    r.hit_kind = hit_code;
    r.hit_total = hit_cnt;
    return r;
  endfunction

  // Advance the tracker by one accepted bin; queue the region it calls, if any
  function automatic void track_bin(input src_in_t b);
    logic [23:0] idx;
    bit emitted;
    idx = bin_idx;
    emitted = 1'b0;
    if (b.read_level >= cfg_model.read_weak_level ||
        b.multi_level >= cfg_model.multi_weak_level ||
        b.read_level <= cfg_model.read_floor_level) begin
      // Flagged bin: open or extend the region, clear the gap run
      miss_cnt = '0;
      reg_last = idx;
      if (!reg_open) begin
        reg_first = idx;
        reg_open = 1'b1;
      end
      if (b.read_level >= cfg_model.read_strong_level) begin
        hit_flag = 1'b1;
        hit_code[0] = 1'b1;
        if (hit_cnt != TALLY_MAX) hit_cnt++;
      end
      if (b.multi_level > cfg_model.multi_strong_level) begin
        hit_flag = 1'b1;
        hit_code[1] = 1'b1;
        if (hit_cnt != TALLY_MAX) hit_cnt++;
      end
    end else if (miss_cnt < cfg_model.gap_limit) begin
      miss_cnt++;
    end else begin
      // Gap used up: close; report only if the region held a strong hit
      reg_open = 1'b0;
      if (hit_flag) begin
        pending_regions.insert(pending_regions.size(), region_report());
        emitted = 1'b1;
        hit_flag = 1'b0;
        hit_code = '0;
        hit_cnt = '0;
      end
    end
    if (b.final_bin) begin
      // Flush an open hit region, then start a fresh sequence
      if (hit_flag && !emitted)
        pending_regions.insert(pending_regions.size(), region_report());
      bin_idx = '0;
      reg_open = 1'b0;
      miss_cnt = '0;
      reg_first = '0;
      reg_last = '0;
      hit_flag = 1'b0;
      hit_code = '0;
      hit_cnt = '0;
    end else begin
      bin_idx = idx + 24'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus shaping
  // ---------------------------------------------------------------------------

  // Random value in [lo, hi], biased toward both ends; lo when the range is empty
  function automatic logic [31:0] pick(input longint lo, input longint hi);
    int r;
    if (lo < 0) lo = 0;
    if (hi > U32_MAX) hi = U32_MAX;
    if (hi < lo) return lo[31:0];
    r = $urandom_range(7, 0);
    if (r == 0) return lo[31:0];
    if (r == 1) return hi[31:0];
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // Build a bin of the given shape against the current thresholds
  function automatic src_in_t make_bin(input bin_kind_e k, input bit fin);
    src_in_t b;
    longint fl, rw, rs, mw, ms;
    fl = longint'(cfg_model.read_floor_level);
    rw = longint'(cfg_model.read_weak_level);
    rs = longint'(cfg_model.read_strong_level);
    mw = longint'(cfg_model.multi_weak_level);
    ms = longint'(cfg_model.multi_strong_level);
    b.final_bin = fin;
    case (k)
      BK_QUIET: begin
        b.read_level = pick(fl + 1, rw - 1);
        b.multi_level = pick(0, mw - 1);
      end
      BK_PLAIN: begin
        if ($urandom_range(1, 0)) b.read_level = pick(rw, rs - 1);
        else b.read_level = pick(0, (fl < rs ? fl : rs - 1));
        b.multi_level = pick(0, ms);
      end
      BK_RHIT: begin
        b.read_level = pick(rs, U32_MAX);
        b.multi_level = pick(0, ms);
      end
      BK_MHIT: begin
        b.read_level = pick(fl + 1, (rw < rs ? rw : rs) - 1);
        b.multi_level = pick((ms + 1 > mw ? ms + 1 : mw), U32_MAX);
      end
      BK_BOTH: begin
        b.read_level = pick(rs, U32_MAX);
        b.multi_level = pick(ms + 1, U32_MAX);
      end
      default: begin
        b.read_level = $urandom;
        b.multi_level = $urandom;
      end
    endcase
    return b;
  endfunction

  task automatic add_bin(input src_in_t b);
    bin_q.insert(bin_q.size(), b);
    fed++;
  endtask

  task automatic push_bin(input logic [31:0] rd, input logic [31:0] mm, input bit fin);
    src_in_t b;
    b.read_level = rd;
    b.multi_level = mm;
    b.final_bin = fin;
    add_bin(b);
  endtask

  // One region: flagged bins with bridged gaps, then a closing gap.
  // A broken region stops short and may end on a final bin instead.
  task automatic add_region(input bit broken);
    int n_flag, gap, tail;
    n_flag = $urandom_range(6, 1);
    for (int i = 0; i < n_flag; i++) begin
      add_bin(make_bin(bin_kind_e'($urandom_range(BK_BOTH, BK_PLAIN)), 1'b0));
      if (i != n_flag - 1) begin
        // Mostly short gaps; now and then bridge the full limit when it is small
        if (cfg_model.gap_limit <= 16 && $urandom_range(5, 0) == 0) gap = cfg_model.gap_limit;
        else gap = $urandom_range((cfg_model.gap_limit < 3 ? cfg_model.gap_limit : 3), 0);
        repeat (gap) add_bin(make_bin(BK_QUIET, 1'b0));
      end
    end
    if (!broken) begin
      // Run past the limit, sometimes by a few bins to close again
      tail = cfg_model.gap_limit + 1 + $urandom_range(2, 0);
      for (int i = 0; i < tail; i++)
        add_bin(make_bin(BK_QUIET, (i == tail - 1) && ($urandom_range(7, 0) == 0)));
    end else begin
      repeat ($urandom_range(2, 0)) add_bin(make_bin(BK_QUIET, 1'b0));
      if ($urandom_range(1, 0))
        add_bin(make_bin(bin_kind_e'($urandom_range(BK_BOTH, BK_QUIET)), 1'b1));
    end
  endtask

  // Mostly well-formed regions, the rest noise bursts and broken regions
  task automatic fill_random(input int count);
    int goal;
    goal = fed + count;
    while (fed < goal) begin
      case ($urandom_range(9, 0))
        7, 8: repeat ($urandom_range(4, 1))
                add_bin(make_bin(BK_NOISE, $urandom_range(15, 0) == 0));
        9: add_region(1'b1);
        default: add_region(1'b0);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes: only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_READ_WEAK:    cfg_model.read_weak_level = val;
      REG_READ_STRONG:  cfg_model.read_strong_level = val;
      REG_MULTI_WEAK:   cfg_model.multi_weak_level = val;
      REG_MULTI_STRONG: cfg_model.multi_strong_level = val;
      REG_READ_FLOOR:   cfg_model.read_floor_level = val;
      REG_WIN_LENGTH:   cfg_model.window_length = val[15:0];
      REG_WIN_STEP:     cfg_model.window_step = val[15:0];
      REG_GAP_LIMIT:    cfg_model.gap_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input src_cfg_t c);
    set_reg(REG_READ_WEAK, c.read_weak_level);
    set_reg(REG_READ_STRONG, c.read_strong_level);
    set_reg(REG_MULTI_WEAK, c.multi_weak_level);
    set_reg(REG_MULTI_STRONG, c.multi_strong_level);
    set_reg(REG_READ_FLOOR, c.read_floor_level);
    set_reg(REG_WIN_LENGTH, 32'(c.window_length));
    set_reg(REG_WIN_STEP, 32'(c.window_step));
    set_reg(REG_GAP_LIMIT, 32'(c.gap_limit));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every bin is taken and every region has come out, then let
  // in-flight bins that call nothing drain through the pipeline
  task automatic wait_drained();
    while (bin_q.size() != 0 || in_push || pending_regions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    fill_random(count);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Bin driver: predict on each transfer, then offer the next bin or idle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit took;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      took = in_push && !in_full;
      if (took) track_bin(in_item);
      // Hold the current bin until it transfers; otherwise choose again
      if (took || !in_push) begin
        if (bin_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          in_push <= 1'b1;
          in_item <= bin_q.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Region monitor: check each transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    src_out_t want;
    int hold_left;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_regions.size() == 0) begin
        $error("region out with none predicted: start %0h end %0h",
               out_item.region_start, out_item.region_end);
        err_count++;
      end else begin
        want = pending_regions.pop_front();
        if (out_item.region_start !== want.region_start) begin
          $error("region_start: expected %0h, got %0h", want.region_start,
                 out_item.region_start);
          err_count++;
        end
        if (out_item.region_end !== want.region_end) begin
          $error("region_end: expected %0h, got %0h", want.region_end, out_item.region_end);
          err_count++;
        end
        if (out_item.hit_kind !== want.hit_kind) begin
          $error("hit_kind: expected %0h, got %0h", want.hit_kind, out_item.hit_kind);
          err_count++;
        end
        if (out_item.hit_total !== want.hit_total) begin
          $error("hit_total: expected %0d, got %0d", want.hit_total, out_item.hit_total);
          err_count++;
        end
      end
    end
    // A hold-off request starts a long stall counted here
    if (rx_hold_req) hold_left = RX_HOLD;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    src_cfg_t rnd_cfg;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: every bin is flagged and counts as a read hit, so
    // nothing closes until the final bin flushes the region
    @(negedge clk);
    push_bin(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_bin(32'h0000_0000, 32'h0000_0001, 1'b1);
    run_phase(0, 0, 0);

    // Mid-range thresholds, gap limit 3
    load_cfg('{read_weak_level: 32'h0002_0000, read_strong_level: 32'h0008_0000,
               multi_weak_level: 32'h0004_0000, multi_strong_level: 32'h0008_0000,
               read_floor_level: 32'h0000_0100, window_length: 16'd1000,
               window_step: 16'd100, gap_limit: 8'd3});
    @(negedge clk);
    // Read exactly at the weak level opens a region without a hit
    push_bin(32'h0002_0000, 32'h0000_0000, 1'b0);
    // Four unflagged bins: the fourth closes it silently
    repeat (4) push_bin(32'h0000_1000, 32'h0003_FFFF, 1'b0);
    // Read at the floor; multi equal to the strong level is no hit
    push_bin(32'h0000_0100, 32'h0008_0000, 1'b0);
    // Read and multi hit in one bin, then both at full scale
    push_bin(32'h0008_0000, 32'h0008_0001, 1'b0);
    push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // Bridge a full gap, extend, then run out of gap and report
    repeat (3) push_bin(32'h0000_1000, 32'h0003_FFFF, 1'b0);
    push_bin(32'h0007_FFFF, 32'h0000_0000, 1'b0);
    repeat (4) push_bin(32'h0001_FFFF, 32'h0000_0000, 1'b0);
    // Zero read is flagged by the floor; final bin flushes the hit region
    push_bin(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_bin(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    // Close and final on the same bin: one result only
    push_bin(32'hFFFF_FFFF, 32'h0003_FFFF, 1'b0);
    repeat (3) push_bin(32'h0000_0101, 32'h0000_0000, 1'b0);
    push_bin(32'h0000_0101, 32'h0000_0000, 1'b1);
    run_phase(300, 0, 0);
    run_phase(300, 72, 0);

    // Zero gap limit and widest windows
    load_cfg('{read_weak_level: 32'h0010_0000, read_strong_level: 32'h0020_0000,
               multi_weak_level: 32'h0001_0000, multi_strong_level: 32'h0001_0000,
               read_floor_level: 32'h0000_0000, window_length: 16'hFFFF,
               window_step: 16'hFFFF, gap_limit: 8'd0});
    run_phase(250, 0, 72);

    // Back-pressure: hold the receiver off while bins keep coming, so the
    // result queue fills and the input stalls
    @(negedge clk);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    fill_random(120);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    wait_drained();

    // Extremes: top thresholds, zero windows, widest gap
    load_cfg('{read_weak_level: 32'hFFFF_FFFF, read_strong_level: 32'hFFFF_FFFF,
               multi_weak_level: 32'hFFFF_FFFF, multi_strong_level: 32'hFFFF_FFFE,
               read_floor_level: 32'h0000_0000, window_length: 16'h0000,
               window_step: 16'h0000, gap_limit: 8'hFF});
    run_phase(350, 30, 30);

    // Random ordered thresholds and windows
    rnd_cfg.read_floor_level = $urandom_range(32'h0FFF_FFFF, 0);
    rnd_cfg.read_weak_level = rnd_cfg.read_floor_level + $urandom_range(32'h0FFF_FFFF, 2);
    rnd_cfg.read_strong_level = rnd_cfg.read_weak_level + $urandom_range(32'h0FFF_FFFF, 0);
    rnd_cfg.multi_weak_level = $urandom_range(32'h1FFF_FFFF, 1);
    rnd_cfg.multi_strong_level = rnd_cfg.multi_weak_level + $urandom_range(32'h0FFF_FFFF, 0);
    rnd_cfg.window_length = $urandom_range(65535, 1);
    rnd_cfg.window_step = $urandom_range(65535, 1);
    rnd_cfg.gap_limit = $urandom_range(8, 0);
    load_cfg(rnd_cfg);
    run_phase(200, 30, 30);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
